// ===== rtl/rhd_pkg.sv =====
package rhd_pkg;

  // Default width of the packet length counter.
  localparam int unsigned PacketLengthBitsDef = 16;

  // Number of commands the queue between front and back can hold.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Fixed RTP header size and the byte value of the last start code byte.
  localparam logic [6:0] RtpFixedHeader = 7'd12;
  localparam logic [7:0] StartCodeLast  = 8'h01;

  // NAL unit type codes.
  localparam logic [4:0] NalSps       = 5'd7;
  localparam logic [4:0] NalPps       = 5'd8;
  localparam logic [4:0] NalStapA     = 5'd24;
  localparam logic [4:0] NalFuA       = 5'd28;
  localparam logic [4:0] NalSingleMax = 5'd23;

  // Result kinds.
  localparam logic KindByte   = 1'b0;
  localparam logic KindCommit = 1'b1;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_NAL_HEAD,
    PH_SINGLE,
    PH_STAP_HI,
    PH_STAP_LO,
    PH_STAP_FIRST,
    PH_STAP_BODY,
    PH_FU_HEAD,
    PH_FU_BODY,
    PH_DROP
  } phase_e;

  // Input word: one packet byte and the packet length.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] packet_bytes;
  } in_word_t;

  // Output word: one Annex-B byte or one commit marker.
  typedef struct packed {
    logic       item_kind;
    logic [7:0] stream_byte;
    logic       codec_config;
    logic       last_of_run;
  } out_word_t;

  // Command from the parser: which results one input byte causes.
  typedef struct packed {
    logic       start_code;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       commit;
    logic       config_nal;
  } cmd_t;

endpackage

// ===== rtl/rhd_front.sv =====
module rhd_front
  import rhd_pkg::*;
#(
  parameter int unsigned PACKET_LENGTH_BITS = PacketLengthBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  output logic     in_stall_o,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned LW = PACKET_LENGTH_BITS;
  localparam int unsigned CW = (LW > 16) ? LW : 16;

  phase_e        phase_q, phase_d, phase_mid;
  logic [LW-1:0] pos_q, pos_d;
  logic [6:0]    hl_q, hl_d;
  logic [15:0]   unit_q, unit_d;
  logic [7:0]    len_hi_q, len_hi_d;
  logic [2:0]    ind_q, ind_d;
  logic          fend_q, fend_d;
  logic          single_cfg_q, single_cfg_d;

  logic          accept;
  logic [7:0]    b;
  logic [4:0]    nal_type;
  logic [LW-1:0] plen;
  logic [LW:0]   pos1;
  logic          last;
  logic [LW-1:0] left;
  logic          pos_zero;
  logic [6:0]    hl_new, hl_eff;
  logic [15:0]   stap_len;
  logic [15:0]   unit_dec;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Position bookkeeping within the current packet.
  assign b        = in_word_i.payload_byte;
  assign nal_type = b[4:0];
  assign plen     = LW'(in_word_i.packet_bytes);
  assign pos1     = (LW+1)'(pos_q) + (LW+1)'(1);
  assign last     = pos1 >= (LW+1)'(plen);
  assign left     = last ? '0 : LW'((LW+1)'(plen) - pos1);
  assign pos_zero = (pos_q == '0);
  assign hl_new   = RtpFixedHeader + {1'b0, b[3:0], 2'b00};
  assign hl_eff   = pos_zero ? hl_new : hl_q;
  assign stap_len = {len_hi_q, b};
  assign unit_dec = unit_q - 16'd1;

  // Next state of the parser.
  always_comb begin
    phase_mid    = phase_q;
    hl_d         = hl_q;
    unit_d       = unit_q;
    len_hi_d     = len_hi_q;
    ind_d        = ind_q;
    fend_d       = fend_q;
    single_cfg_d = single_cfg_q;
    case (phase_q)
      PH_HEADER: begin
        if (pos_zero) begin
          hl_d = hl_new;
        end
        if (pos_zero && (CW'(plen) < CW'(hl_eff))) begin
          phase_mid = PH_DROP;
        end else if (pos1 >= (LW+1)'(hl_eff)) begin
          phase_mid = PH_NAL_HEAD;
        end
      end
      PH_NAL_HEAD: begin
        if (nal_type <= NalSingleMax) begin
          single_cfg_d = (nal_type == NalSps) || (nal_type == NalPps);
          phase_mid    = PH_SINGLE;
        end else if (nal_type == NalStapA) begin
          phase_mid = PH_STAP_HI;
        end else if (nal_type == NalFuA) begin
          ind_d     = b[7:5];
          phase_mid = PH_FU_HEAD;
        end else begin
          phase_mid = PH_DROP;
        end
      end
      PH_STAP_HI: begin
        len_hi_d  = b;
        phase_mid = PH_STAP_LO;
      end
      PH_STAP_LO: begin
        if (CW'(stap_len) > CW'(left)) begin
          phase_mid = PH_DROP;
        end else if (stap_len == 16'd0) begin
          phase_mid = PH_STAP_HI;
        end else begin
          unit_d    = stap_len;
          phase_mid = PH_STAP_FIRST;
        end
      end
      PH_STAP_FIRST, PH_STAP_BODY: begin
        unit_d    = unit_dec;
        phase_mid = (unit_dec == 16'd0) ? PH_STAP_HI : PH_STAP_BODY;
      end
      PH_FU_HEAD: begin
        fend_d    = b[6];
        phase_mid = PH_FU_BODY;
      end
      default: begin
      end
    endcase
    phase_d = last ? PH_HEADER : phase_mid;
    pos_d   = last ? '0 : LW'(pos1);
  end

  // Command for the back end.
  always_comb begin
    cmd_o = '0;
    case (phase_q)
      PH_NAL_HEAD: begin
        if (nal_type <= NalSingleMax) begin
          cmd_o.start_code = 1'b1;
          cmd_o.has_byte   = 1'b1;
          cmd_o.data_byte  = b;
        end
      end
      PH_SINGLE, PH_FU_BODY, PH_STAP_BODY: begin
        cmd_o.has_byte  = 1'b1;
        cmd_o.data_byte = b;
      end
      PH_STAP_FIRST: begin
        cmd_o.start_code = 1'b1;
        cmd_o.has_byte   = 1'b1;
        cmd_o.data_byte  = b;
      end
      PH_FU_HEAD: begin
        if (b[7]) begin
          cmd_o.start_code = 1'b1;
          cmd_o.has_byte   = 1'b1;
          cmd_o.data_byte  = {ind_q, b[4:0]};
        end
      end
      default: begin
      end
    endcase
    // A STAP-A unit commits on its last byte; a single NAL and an FU-A end fragment commit at packet end.
    if ((phase_q == PH_STAP_FIRST || phase_q == PH_STAP_BODY) && unit_dec == 16'd0) begin
      cmd_o.commit = 1'b1;
    end
    if (last && phase_mid == PH_SINGLE) begin
      cmd_o.commit     = 1'b1;
      cmd_o.config_nal = single_cfg_d;
    end
    if (last && phase_mid == PH_FU_BODY && fend_d) begin
      cmd_o.commit = 1'b1;
    end
  end

  assign push_o = accept && (cmd_o.start_code || cmd_o.has_byte || cmd_o.commit);

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      hl_q         <= RtpFixedHeader;
      unit_q       <= '0;
      len_hi_q     <= '0;
      ind_q        <= '0;
      fend_q       <= 1'b0;
      single_cfg_q <= 1'b0;
    end else if (accept) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      hl_q         <= hl_d;
      unit_q       <= unit_d;
      len_hi_q     <= len_hi_d;
      ind_q        <= ind_d;
      fend_q       <= fend_d;
      single_cfg_q <= single_cfg_d;
    end
  end

endmodule

// ===== rtl/rhd_queue.sv =====
module rhd_queue
  import rhd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/rhd_back.sv =====
module rhd_back
  import rhd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  // Result slots of one command, in output order.
  localparam logic [2:0] SlotSc0    = 3'd0;
  localparam logic [2:0] SlotSc3    = 3'd3;
  localparam logic [2:0] SlotByte   = 3'd4;
  localparam logic [2:0] SlotCommit = 3'd5;

  logic       mid_q, mid_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;

  logic       advance;
  logic [2:0] first_slot, cur_slot, next_slot;
  logic       is_last;
  out_word_t  word;

  assign advance = head_valid_i && (!out_valid_q || !out_stall_i);

  // Slot selection within the command at the head of the queue.
  always_comb begin
    if (head_cmd_i.start_code) begin
      first_slot = SlotSc0;
    end else if (head_cmd_i.has_byte) begin
      first_slot = SlotByte;
    end else begin
      first_slot = SlotCommit;
    end
    cur_slot  = mid_q ? step_q : first_slot;
    next_slot = cur_slot;
    is_last   = 1'b1;
    if (cur_slot < SlotSc3) begin
      next_slot = cur_slot + 3'd1;
      is_last   = 1'b0;
    end else if (cur_slot == SlotSc3) begin
      if (head_cmd_i.has_byte) begin
        next_slot = SlotByte;
        is_last   = 1'b0;
      end else if (head_cmd_i.commit) begin
        next_slot = SlotCommit;
        is_last   = 1'b0;
      end
    end else if (cur_slot == SlotByte && head_cmd_i.commit) begin
      next_slot = SlotCommit;
      is_last   = 1'b0;
    end
  end

  // Output word for the current slot.
  always_comb begin
    word             = '0;
    word.item_kind   = KindByte;
    word.last_of_run = is_last;
    if (cur_slot == SlotSc3) begin
      word.stream_byte = StartCodeLast;
    end else if (cur_slot == SlotByte) begin
      word.stream_byte = head_cmd_i.data_byte;
    end else if (cur_slot == SlotCommit) begin
      word.item_kind    = KindCommit;
      word.codec_config = head_cmd_i.config_nal;
    end
  end

  // Next state of the slot sequencer and the output register.
  always_comb begin
    mid_d       = mid_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = word;
      if (is_last) begin
        pop_o = 1'b1;
        mid_d = 1'b0;
      end else begin
        mid_d  = 1'b1;
        step_d = next_slot;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      step_q      <= SlotSc0;
      out_valid_q <= 1'b0;
    end else begin
      mid_q       <= mid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A command in progress keeps its entry at the head of the queue.
  a_mid_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q |-> head_valid_i)
    else $error("command in progress without a queue entry");

  // A commit marker always closes the run of its input byte.
  a_commit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.item_kind == KindCommit) |-> (out_q.last_of_run
      && out_q.stream_byte == 8'd0))
    else $error("commit marker not at end of run");

  // The word after the last start code byte is never a start code byte.
  a_after_sc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cur_slot == SlotSc3) |=> (mid_q && step_q > SlotSc3))
    else $error("start code not followed by byte or commit");

endmodule

// ===== rtl/rtp_h264_depacketizer.sv =====
// Channel  | valid       | stall        | word
// ---------+-------------+--------------+------------------------
// input    | in_valid_i  | in_stall_o   | in_word_i  (in_word_t)
// output   | out_valid_o | out_stall_i  | out_word_o (out_word_t)
//
// The parser takes one packet byte every cycle while the command queue has room.
// Each byte with results turns into one queued command; the back end sends one
// output word per cycle while the output is not stalled, so such a byte yields 1 to 6
// output words (5 or 6 with a start code, 6 when the unit also commits).
// The four-entry command queue absorbs start code bursts; input stalls only when it fills.
// Reset clears the parser, the queue pointers and the output valid; no clearing pass follows.
module rtp_h264_depacketizer
  import rhd_pkg::*;
#(
  parameter int unsigned PACKET_LENGTH_BITS = PacketLengthBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_word_t  in_word_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Packet parser.
  rhd_front #(
    .PACKET_LENGTH_BITS(PACKET_LENGTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_word_i (in_word_i),
    .in_stall_o(in_stall_o),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Command queue between parser and output sequencer.
  rhd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_cmd_o  (head_cmd)
  );

  // Output sequencer.
  rhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_cmd_i  (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== dv/tb_rtp_h264_depacketizer.sv =====
import rhd_pkg::*;

// Tracks the depacketizer state and holds the Annex-B words it must produce.
class annexb_tracker;
  phase_e      phase;
  logic [15:0] position;
  logic [6:0]  hdr_len;
  logic [15:0] unit_left;
  logic [7:0]  len_hi;
  logic [2:0]  nri_bits;
  logic        frag_end;
  logic        single_cfg;
  out_word_t   expected_words[$];
  int          mismatches;
  int          words_checked;
  int          commits_seen;
  int          config_commits;

  function new();
    phase          = PH_HEADER;
    position       = '0;
    hdr_len        = RtpFixedHeader;
    unit_left      = '0;
    len_hi         = '0;
    nri_bits       = '0;
    frag_end       = 1'b0;
    single_cfg     = 1'b0;
    mismatches     = 0;
    words_checked  = 0;
    commits_seen   = 0;
    config_commits = 0;
  endfunction

  function void add(logic kind, logic [7:0] data, logic cfg);
    out_word_t w;
    w.item_kind    = kind;
    w.stream_byte  = data;
    w.codec_config = cfg;
    w.last_of_run  = 1'b0;
    expected_words.push_back(w);
  endfunction

  function void add_start_code();
    add(KindByte, 8'h00, 1'b0);
    add(KindByte, 8'h00, 1'b0);
    add(KindByte, 8'h00, 1'b0);
    add(KindByte, StartCodeLast, 1'b0);
  endfunction

  // Advance the parser by one accepted packet byte and queue what it yields.
  function void note_packet_byte(in_word_t w);
    logic [7:0]  b;
    logic [16:0] plen;
    logic [16:0] nxt;
    logic [16:0] left;
    logic [15:0] unit_len;
    logic        last;
    int          first;
    out_word_t   tail;
    b     = w.payload_byte;
    plen  = {1'b0, w.packet_bytes};
    nxt   = {1'b0, position} + 17'd1;
    last  = (nxt >= plen);
    left  = last ? 17'd0 : plen - nxt;
    first = expected_words.size();
    case (phase)
      PH_HEADER: begin
        // The first byte sets the header size from the CSRC count.
        if (position == 16'd0) begin
          hdr_len = RtpFixedHeader + {b[3:0], 2'b00};
          if (plen < hdr_len) phase = PH_DROP;
        end
        if (phase == PH_HEADER && nxt >= hdr_len) phase = PH_NAL_HEAD;
      end
      PH_NAL_HEAD: begin
        if (b[4:0] <= NalSingleMax) begin
          add_start_code();
          add(KindByte, b, 1'b0);
          single_cfg = (b[4:0] == NalSps) || (b[4:0] == NalPps);
          phase = PH_SINGLE;
        end else if (b[4:0] == NalStapA) begin
          phase = PH_STAP_HI;
        end else if (b[4:0] == NalFuA) begin
          nri_bits = b[7:5];
          phase = PH_FU_HEAD;
        end else begin
          phase = PH_DROP;
        end
      end
      PH_SINGLE, PH_FU_BODY: add(KindByte, b, 1'b0);
      PH_STAP_HI: begin
        len_hi = b;
        phase = PH_STAP_LO;
      end
      PH_STAP_LO: begin
        // An overlong unit ends the packet; a zero length is skipped.
        unit_len = {len_hi, b};
        if ({1'b0, unit_len} > left) begin
          phase = PH_DROP;
        end else if (unit_len == 16'd0) begin
          phase = PH_STAP_HI;
        end else begin
          unit_left = unit_len;
          phase = PH_STAP_FIRST;
        end
      end
      PH_STAP_FIRST, PH_STAP_BODY: begin
        if (phase == PH_STAP_FIRST) add_start_code();
        add(KindByte, b, 1'b0);
        unit_left = unit_left - 16'd1;
        if (unit_left == 16'd0) begin
          add(KindCommit, 8'h00, 1'b0);
          phase = PH_STAP_HI;
        end else begin
          phase = PH_STAP_BODY;
        end
      end
      PH_FU_HEAD: begin
        // Only a start fragment rebuilds the NAL header.
        frag_end = b[6];
        if (b[7]) begin
          add_start_code();
          add(KindByte, {nri_bits, b[4:0]}, 1'b0);
        end
        phase = PH_FU_BODY;
      end
      default: ;
    endcase
    // Packet end: commit a single NAL, or a fragment carrying the end bit.
    if (last) begin
      if (phase == PH_SINGLE) add(KindCommit, 8'h00, single_cfg);
      else if (phase == PH_FU_BODY && frag_end) add(KindCommit, 8'h00, 1'b0);
      phase = PH_HEADER;
      position = '0;
    end else begin
      position = nxt[15:0];
    end
    if (expected_words.size() > first) begin
      tail = expected_words.pop_back();
      tail.last_of_run = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
  endfunction

  // Compare one accepted output word with the oldest expected word.
  function void check_stream_word(out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output word, expected none, got %h", $time, got);
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      if (got.item_kind === KindCommit) begin
        commits_seen++;
        if (got.codec_config === 1'b1) config_commits++;
      end
      if (got.item_kind !== want.item_kind)
        report("item_kind", want.item_kind, got.item_kind);
      if (got.stream_byte !== want.stream_byte)
        report("stream_byte", want.stream_byte, got.stream_byte);
      if (got.codec_config !== want.codec_config)
        report("codec_config", want.codec_config, got.codec_config);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    end
  endfunction
endclass

module tb_rtp_h264_depacketizer;

  localparam int          HalfPeriod  = 5;
  localparam int          HoldCycles  = 120;
  localparam int          DrainCycles = 20;
  localparam int unsigned PhaseBytes  = 28;
  // Worst case: six words per byte, each behind a long stall, or the hold-off.
  localparam int          QuietLimit  = 4000;
  localparam logic [4:0]  NalSlice    = 5'd1;
  localparam logic [4:0]  NalTypeMax  = 5'd31;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;
  logic      out_stall_i = 1'b0;

  annexb_tracker annexb;
  logic [7:0]    pkt[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  int unsigned   bytes_sent    = 0;
  int unsigned   packets_sent  = 0;
  int            quiet_cycles  = 0;
  int            hold_left     = 0;
  bit            hold_go       = 1'b0;

  rtp_h264_depacketizer i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_word_i,
    .in_stall_o,
    .out_valid_o,
    .out_word_o,
    .out_stall_i
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Output side: check accepted words, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) annexb.check_stream_word(out_word_o);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one input word, idling at random first, and wait until it is taken.
  task automatic send_word(input logic [7:0] data, input logic [15:0] plen);
    in_word_t w;
    w.payload_byte = data;
    w.packet_bytes = plen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    annexb.note_packet_byte(w);
    bytes_sent++;
  endtask

  // Drop the input valid and wait for every expected word to arrive.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (annexb.expected_words.size() != 0);
  endtask

  function automatic void start_rtp(input logic [3:0] csrc);
    pkt.delete();
    pkt.push_back({2'b10, 2'($urandom), csrc});
    repeat (11 + 4 * csrc) pkt.push_back(8'($urandom));
  endfunction

  function automatic void add_body(input int count);
    repeat (count) pkt.push_back(8'($urandom));
  endfunction

  function automatic void add_stap_unit(input logic [15:0] len);
    pkt.push_back(len[15:8]);
    pkt.push_back(len[7:0]);
    add_body(len);
  endfunction

  // Send the built packet; a ragged packet carries odd lengths and ends early.
  task automatic send_packet(input bit ragged);
    logic [15:0] total;
    total = 16'(pkt.size());
    foreach (pkt[i]) begin
      if (!ragged) send_word(pkt[i], total);
      else if (i == pkt.size() - 1) send_word(pkt[i], 16'($urandom_range(0, pkt.size())));
      else send_word(pkt[i], ($urandom_range(2) == 0) ? 16'($urandom) : total);
    end
    packets_sent++;
  endtask

  // Send up to the cut byte with an all-ones length, then end it with zero.
  task automatic send_cut(input int cut);
    for (int i = 0; i <= cut; i++) send_word(pkt[i], (i == cut) ? 16'h0000 : 16'hFFFF);
    packets_sent++;
  endtask

  // Mostly well-formed packets of every kind, with some broken ones.
  task automatic send_random_packet();
    int unsigned pick;
    int unsigned keep;
    logic [4:0]  nal_type;
    pick = $urandom_range(9);
    start_rtp(($urandom_range(3) == 0) ? 4'd1 : 4'd0);
    case (pick)
      0, 1, 2: begin
        if ($urandom_range(3) == 0) nal_type = $urandom_range(1) ? NalSps : NalPps;
        else nal_type = 5'($urandom_range(NalSingleMax));
        pkt.push_back({3'($urandom), nal_type});
        add_body($urandom_range(5));
      end
      3, 4: begin
        pkt.push_back({3'($urandom), NalStapA});
        repeat ($urandom_range(1, 3)) add_stap_unit(16'($urandom_range(4)));
        if ($urandom_range(3) == 0) begin
          pkt.push_back(8'($urandom));
        end else if ($urandom_range(3) == 0) begin
          // A random length with one byte behind it is almost always overlong.
          pkt.push_back(8'($urandom));
          pkt.push_back(8'($urandom));
          add_body(1);
        end
      end
      5, 6: begin
        pkt.push_back({3'($urandom), NalFuA});
        pkt.push_back(8'($urandom));
        add_body($urandom_range(4));
      end
      7: begin
        nal_type = 5'($urandom_range(NalStapA + 1, NalTypeMax));
        if (nal_type == NalFuA) nal_type = NalTypeMax;
        pkt.push_back({3'($urandom), nal_type});
        add_body($urandom_range(2));
      end
      8: begin
        start_rtp(4'($urandom_range(1, 15)));
        keep = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > keep) void'(pkt.pop_back());
      end
      default: begin
        pkt.push_back(8'($urandom));
        add_body($urandom_range(3));
      end
    endcase
    send_packet(pick == 9 || $urandom_range(15) == 0);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned stall_v);
    int unsigned start;
    send_idle_pct = send_pct;
    stall_pct     = stall_v;
    start         = bytes_sent;
    while (bytes_sent - start < PhaseBytes) send_random_packet();
    wait_drain();
  endtask

  initial begin
    annexb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short packet: the CSRC count asks for more header than the packet has.
    pkt.delete();
    pkt.push_back(8'hFF);
    add_body(4);
    send_packet(1'b0);
    // Header only, with two CSRC entries.
    start_rtp(4'd2);
    send_packet(1'b0);
    // Single SPS with extreme payload bytes, then a bare PPS.
    start_rtp(4'd1);
    pkt.push_back({3'b011, NalSps});
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    send_packet(1'b0);
    start_rtp(4'd0);
    pkt.push_back({3'b000, NalPps});
    send_packet(1'b0);
    // Unknown type with all header bits set.
    start_rtp(4'd0);
    pkt.push_back(8'hFF);
    add_body(1);
    send_packet(1'b0);
    // STAP-A with a zero length, two units and a trailing byte.
    start_rtp(4'd0);
    pkt.push_back({3'b011, NalStapA});
    add_stap_unit(16'd0);
    add_stap_unit(16'd2);
    add_stap_unit(16'd1);
    add_body(1);
    send_packet(1'b0);
    // STAP-A whose first length exceeds the bytes left.
    start_rtp(4'd0);
    pkt.push_back({3'b010, NalStapA});
    pkt.push_back(8'hFF);
    pkt.push_back(8'hFF);
    add_body(2);
    send_packet(1'b0);
    // STAP-A cut inside a unit by a zero packet length.
    start_rtp(4'd0);
    pkt.push_back({3'b001, NalStapA});
    add_stap_unit(16'd3);
    send_cut(pkt.size() - 2);
    // FU-A start, middle and end fragments.
    start_rtp(4'd0);
    pkt.push_back({3'b010, NalFuA});
    pkt.push_back({3'b100, NalSlice});
    add_body(2);
    send_packet(1'b0);
    start_rtp(4'd0);
    pkt.push_back({3'b010, NalFuA});
    pkt.push_back({3'b000, NalSlice});
    add_body(1);
    send_packet(1'b0);
    start_rtp(4'd0);
    pkt.push_back({3'b010, NalFuA});
    pkt.push_back({3'b010, NalSlice});
    add_body(1);
    send_packet(1'b0);
    // FU-A packet ending before its FU header.
    start_rtp(4'd0);
    pkt.push_back({3'b110, NalFuA});
    send_packet(1'b0);
    wait_drain();

    // Back-pressure: hold the output while a long NAL keeps coming.
    hold_go = 1'b1;
    start_rtp(4'd0);
    pkt.push_back({3'b011, NalSlice});
    add_body(24);
    send_packet(1'b0);
    wait_drain();

    run_random_phase(0, 0);
    run_random_phase(86, 0);
    run_random_phase(0, 86);
    run_random_phase(18, 18);

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d packet bytes in %0d packets; checked %0d output words.",
             bytes_sent, packets_sent, annexb.words_checked);
    $display("Saw %0d unit commits (%0d parameter sets) over single, STAP-A and FU-A traffic.",
             annexb.commits_seen, annexb.config_commits);
    if (annexb.mismatches == 0 && annexb.expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rhd_pkg.sv
rtl/rhd_front.sv
rtl/rhd_queue.sv
rtl/rhd_back.sv
rtl/rtp_h264_depacketizer.sv
dv/tb_rtp_h264_depacketizer.sv
